>>> hw/rtl/in_order_release_buffer_macros.svh
// Assertion macros for the in-order release buffer.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef IN_ORDER_RELEASE_BUFFER_MACROS_SVH
`define IN_ORDER_RELEASE_BUFFER_MACROS_SVH

// Same-cycle implication, checks off while reset is high.
`define IORB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checks off while reset is high.
`define IORB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/iorb_pkg.sv
// Shared types and constants for the in-order release buffer.
// No dependencies.
package iorb_pkg;

  localparam int WINDOW = 32;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SEQ_W  = 32;
  localparam int PL_W   = 32;

  localparam logic [1:0] ST_RELEASED  = 2'd0;
  localparam logic [1:0] ST_UNORDERED = 2'd1;
  localparam logic [1:0] ST_STALE     = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  typedef struct packed {
    logic             is_ordered;
    logic [SEQ_W-1:0] seq_num;
    logic [PL_W-1:0]  payload;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEQ_W-1:0] out_seq;
    logic [PL_W-1:0]  out_payload;
    logic             last;
  } result_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic fetch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ordered;
    logic in_window;
    logic head_valid;
    logic next_valid;
  } stat_t;

endpackage

>>> hw/rtl/iorb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iorb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/iorb_ctrl.sv
// Controller for the in-order release buffer: sequences capture, window
// check, slot fetch and release. Depends on iorb_pkg.
module iorb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  iorb_pkg::stat_t stat,
  output iorb_pkg::cmd_t  cmd,
  output logic           busy
);

  import iorb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_FETCH = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    busy        = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.ordered && stat.in_window) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        if (stat.head_valid) begin
          cmd.fetch  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.next_valid) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/iorb_datapath.sv
// Datapath for the in-order release buffer: input register, expected
// sequence counter, slot valid bits, payload RAM and result register.
// Depends on iorb_pkg and iorb_ram.
module iorb_datapath (
  input  logic             clk,
  input  logic             rst,
  input  iorb_pkg::item_t  item,
  input  iorb_pkg::cmd_t   cmd,
  output iorb_pkg::stat_t  stat,
  output iorb_pkg::result_t result,
  output logic             result_valid
);

  import iorb_pkg::*;

  item_t            item_q;
  logic [SEQ_W-1:0] exp_seq;
  logic [WINDOW-1:0] slot_valid;
  logic [SEQ_W-1:0] offset;
  logic             in_window;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] next_idx;
  logic             we;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [PL_W-1:0]  rdata;
  logic             direct;

  assign offset    = item_q.seq_num - exp_seq;
  assign in_window = offset < SEQ_W'(WINDOW);
  assign wr_idx    = item_q.seq_num[IDX_W-1:0];
  assign head_idx  = exp_seq[IDX_W-1:0];
  assign next_idx  = head_idx + IDX_W'(1);
  assign direct    = !(item_q.is_ordered && in_window);

  assign we    = cmd.eval && !direct;
  assign re    = cmd.fetch || cmd.emit;
  assign raddr = cmd.emit ? next_idx : head_idx;

  assign stat.ordered    = item_q.is_ordered;
  assign stat.in_window  = in_window;
  assign stat.head_valid = slot_valid[head_idx];
  assign stat.next_valid = slot_valid[next_idx];

  iorb_ram #(
    .WIDTH(PL_W),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_idx),
    .wdata(item_q.payload),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_seq    <= SEQ_W'(1);
      slot_valid <= '0;
    end else begin
      if (we) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (cmd.emit) begin
        slot_valid[head_idx] <= 1'b0;
        exp_seq              <= exp_seq + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.eval && direct) || cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status      <= ST_RELEASED;
      result.out_seq     <= exp_seq;
      result.out_payload <= rdata;
      result.last        <= !slot_valid[next_idx];
    end else if (cmd.eval && direct) begin
      result.out_payload <= item_q.payload;
      result.last        <= 1'b1;
      if (!item_q.is_ordered) begin
        result.status  <= ST_UNORDERED;
        result.out_seq <= '0;
      end else begin
        result.status  <= (item_q.seq_num < exp_seq) ? ST_STALE : ST_BEYOND;
        result.out_seq <= item_q.seq_num;
      end
    end
  end

endmodule

>>> hw/rtl/in_order_release_buffer.sv
// In-order release buffer: reorders sequenced messages over a 32-slot window.
// Top level; depends on iorb_pkg, iorb_ctrl, iorb_datapath and the macros header.
//
// Usage:
//   Input: an item (is_ordered, seq_num, payload) transfers on a rising edge
//   with start high and busy low. Output: each result sits on result for one
//   cycle with result_valid high; the receiver cannot stall it.
//   Flow: an unordered, stale or beyond-window item gives its one result,
//   and the block takes a new item only after busy falls. An ordered item
//   in the window is written to its slot, then the head slot, if valid, is
//   fetched from the payload RAM; releases follow one per cycle. The
//   registered read of the payload RAM is why a fetch step comes first.
//   Reset: expected sequence number becomes 1 and all slot valid bits clear
//   at once; no clearing pass is needed and an item may start right after.
module in_order_release_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  iorb_pkg::item_t     item,
  output iorb_pkg::result_t   result,
  output logic                result_valid
);

  import iorb_pkg::*;

  `include "in_order_release_buffer_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  iorb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  iorb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

  `IORB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised after transfer")
  `IORB_ASSERT_NEXT(a_emit_strobe, clk, rst, cmd.emit, result_valid, "release without result strobe")
  `IORB_ASSERT_NOW(a_single_last, clk, rst, result_valid && result.status != ST_RELEASED, result.last, "single result missing last")
  `IORB_ASSERT_NOW(a_unord_seq, clk, rst, result_valid && result.status == ST_UNORDERED, result.out_seq == '0, "unordered result with nonzero seq")

endmodule
